FILE: hdl/tlpeq_pkg.sv
// Types and constants for the three-level priority event queue.
// No dependencies; imported by the queue unit and its checker.
`default_nettype none

package tlpeq_pkg;

  localparam int NUM_LEVELS = 3;
  localparam int LVL_W      = 2;
  localparam int ID_W       = 16;
  localparam int HANDLE_W   = 8;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [LVL_W-1:0] LVL_LOW = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ = 2'd0,
    OP_DSP = 2'd1,
    OP_REM = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED   = 3'd0,
    ST_FULL       = 3'd1,
    ST_DISPATCHED = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_REMOVED    = 3'd4,
    ST_NOTFOUND   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_WR,
    S_DSP_WR,
    S_REM_CHK,
    S_REM_FREE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]     ident;
    logic [HANDLE_W-1:0] device;
    logic [HANDLE_W-1:0] sensor;
  } entry_t;

  typedef struct packed {
    logic [5:0]          rsvd;
    logic [HANDLE_W-1:0] sensor_handle;
    logic [HANDLE_W-1:0] device_handle;
    logic [ID_W-1:0]     event_id;
    logic [LVL_W-1:0]    level;
  } in_data_t;

  typedef struct packed {
    logic [5:0]          rsvd;
    logic [HANDLE_W-1:0] out_sensor;
    logic [HANDLE_W-1:0] out_device;
    logic [ID_W-1:0]     out_event_id;
    logic [LVL_W-1:0]    out_level;
  } out_data_t;

endpackage

`default_nettype wire

FILE: hdl/three_level_priority_event_queue_unit.sv
// Three-level strict priority event queue over a shared linked entry pool.
// Depends on tlpeq_pkg for opcodes, status codes, states and payload layouts.
//
// Usage: each input transaction carries an opcode in tuser (enqueue, dispatch,
// remove by id) and the level, event id and handles in tdata; every opcode
// except the undefined one returns exactly one result transaction whose
// tuser is the status and whose tdata holds the dispatched event (all zero
// unless the status is "dispatched"). Three FIFO queues share POOL_DEPTH
// entries kept in two single-port-write, registered-read memories: a payload
// memory and a link memory, with a free list threaded through the links.
// Entries never yet allocated are tracked by a fill count, so no clearing
// pass is needed after reset. Enqueue and dispatch are accepted and then
// finish with the queue pointer update; pool full, all empty and remove on an
// empty queue are accepted and then finish in a done state. Remove walks its
// queue from the head, one link memory read per visited entry, then unlinks
// and frees a matching entry or ends at the tail with "not found". The
// undefined opcode is consumed with no result. A finished result waits in the
// output register while the next transaction is taken; the block holds its
// last step only if a new result finds that register still occupied.
`default_nettype none

module three_level_priority_event_queue_unit #(
  parameter int POOL_DEPTH = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // input transactions
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: level[1:0], event_id[17:2], device_handle[25:18],
  //        sensor_handle[33:26], zero fill[39:34]
  input  wire  [tlpeq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: op[1:0]
  input  wire  [tlpeq_pkg::OP_W-1:0]          s_axis_tuser,
  // result transactions
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // tdata: out_level[1:0], out_event_id[17:2], out_device[25:18],
  //        out_sensor[33:26], zero fill[39:34]
  output logic [tlpeq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: status[2:0]
  output logic [tlpeq_pkg::STATUS_W-1:0]      m_axis_tuser
);

  import tlpeq_pkg::*;

  // Pointers carry one extra code, POOL_DEPTH, as the null link.
  localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
  localparam int ADDR_W = $clog2(POOL_DEPTH);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);

  function automatic logic is_entry(input logic [PTR_W-1:0] p);
    return p < NULL_PTR;
  endfunction

  // ---------------------------------------------------------------------
  // Storage
  // ---------------------------------------------------------------------
  logic [PTR_W-1:0] link_mem [POOL_DEPTH];
  entry_t           pay_mem  [POOL_DEPTH];

  // ---------------------------------------------------------------------
  // Control and queue state
  // ---------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [PTR_W-1:0] head_q [NUM_LEVELS];
  logic [PTR_W-1:0] head_d [NUM_LEVELS];
  logic [PTR_W-1:0] tail_q [NUM_LEVELS];
  logic [PTR_W-1:0] tail_d [NUM_LEVELS];
  logic [PTR_W-1:0] free_q, free_d;     // head of the free list
  logic [PTR_W-1:0] fresh_q, fresh_d;   // first entry never allocated

  // Per-transaction working registers
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [PTR_W-1:0] cur_q, cur_d;
  logic [PTR_W-1:0] prev_q, prev_d;
  status_e          done_status_q, done_status_d;

  // Registered memory read data
  logic [PTR_W-1:0] rd_link_q;
  entry_t           rd_pay_q;

  // Output register
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  out_data_t        out_data_q, out_data_d;

  // Memory port controls
  logic             rd_en;
  logic [PTR_W-1:0] rd_ptr;
  logic             link_we;
  logic [PTR_W-1:0] link_wa;
  logic [PTR_W-1:0] link_wd;
  logic             pay_we;

  // Step completion and result
  logic             fin;
  logic             adv;
  logic             out_free;
  status_e          res_status;
  out_data_t        res_data;

  in_data_t         in_data;
  op_e              in_op;
  logic [LVL_W-1:0] in_lvl;
  logic             accept;

  logic             dsp_found;
  logic [LVL_W-1:0] dsp_lvl;
  logic             rem_match;

  assign in_data  = in_data_t'(s_axis_tdata);
  assign in_op    = op_e'(s_axis_tuser);
  // Level three folds into the low queue.
  assign in_lvl   = (in_data.level == 2'd3) ? LVL_LOW : in_data.level;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign out_free = !out_valid_q || m_axis_tready;
  // Hold a finishing step until the output register can take its result.
  assign adv      = !fin || out_free;

  assign rem_match = (rd_pay_q.ident == id_q);

  // Highest non-empty queue for dispatch.
  always_comb begin
    dsp_found = 1'b0;
    dsp_lvl   = LVL_LOW;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (is_entry(head_q[i])) begin
        dsp_found = 1'b1;
        dsp_lvl   = LVL_W'(i);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_op)
            OP_ENQ:  state_d = is_entry(free_q) ? S_ENQ_WR : S_DONE;
            OP_DSP:  state_d = dsp_found ? S_DSP_WR : S_DONE;
            OP_REM:  state_d = is_entry(head_q[in_lvl]) ? S_REM_CHK : S_DONE;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_REM_CHK: begin
        if (rem_match) begin
          state_d = S_REM_FREE;
        end else if (is_entry(rd_link_q)) begin
          state_d = S_REM_CHK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ENQ_WR, S_DSP_WR, S_REM_FREE, S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath, memory controls and result
  // ---------------------------------------------------------------------
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    free_d        = free_q;
    fresh_d       = fresh_q;
    lvl_d         = lvl_q;
    id_d          = id_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    done_status_d = done_status_q;
    rd_en         = 1'b0;
    rd_ptr        = cur_q;
    link_we       = 1'b0;
    link_wa       = free_q;
    link_wd       = NULL_PTR;
    pay_we        = 1'b0;
    fin           = 1'b0;
    res_status    = done_status_q;
    res_data      = '0;

    case (state_q)
      S_IDLE: begin
        id_d  = in_data.event_id;
        lvl_d = in_lvl;
        if (accept) begin
          case (in_op)
            OP_ENQ: begin
              if (is_entry(free_q)) begin
                // Fetch the free entry's link, seal it and store the payload.
                rd_en   = 1'b1;
                rd_ptr  = free_q;
                link_we = 1'b1;
                link_wa = free_q;
                link_wd = NULL_PTR;
                pay_we  = 1'b1;
              end else begin
                done_status_d = ST_FULL;
              end
            end
            OP_DSP: begin
              if (dsp_found) begin
                // Read the head and push it onto the free list at once.
                lvl_d   = dsp_lvl;
                rd_en   = 1'b1;
                rd_ptr  = head_q[dsp_lvl];
                link_we = 1'b1;
                link_wa = head_q[dsp_lvl];
                link_wd = free_q;
                free_d  = head_q[dsp_lvl];
              end else begin
                done_status_d = ST_EMPTY;
              end
            end
            OP_REM: begin
              if (is_entry(head_q[in_lvl])) begin
                rd_en  = 1'b1;
                rd_ptr = head_q[in_lvl];
                cur_d  = head_q[in_lvl];
                prev_d = NULL_PTR;
              end else begin
                done_status_d = ST_NOTFOUND;
              end
            end
            default: ;
          endcase
        end
      end

      S_ENQ_WR: begin
        fin        = 1'b1;
        res_status = ST_ENQUEUED;
        // An entry at the fill count has no valid link; the next free one follows it.
        if (free_q == fresh_q) begin
          free_d  = free_q + PTR_ONE;
          fresh_d = fresh_q + PTR_ONE;
        end else begin
          free_d = rd_link_q;
        end
        if (!is_entry(head_q[lvl_q])) begin
          head_d[lvl_q] = free_q;
        end else if (is_entry(tail_q[lvl_q])) begin
          link_we = 1'b1;
          link_wa = tail_q[lvl_q];
          link_wd = free_q;
        end
        tail_d[lvl_q] = free_q;
      end

      S_DSP_WR: begin
        fin                   = 1'b1;
        res_status            = ST_DISPATCHED;
        res_data.out_level    = lvl_q;
        res_data.out_event_id = rd_pay_q.ident;
        res_data.out_device   = rd_pay_q.device;
        res_data.out_sensor   = rd_pay_q.sensor;
        head_d[lvl_q]         = rd_link_q;
        if (!is_entry(rd_link_q)) begin
          tail_d[lvl_q] = NULL_PTR;
        end
      end

      S_REM_CHK: begin
        if (rem_match) begin
          // Unlink: patch the predecessor or the head, then fix the tail.
          if (is_entry(prev_q)) begin
            link_we = 1'b1;
            link_wa = prev_q;
            link_wd = rd_link_q;
          end else begin
            head_d[lvl_q] = rd_link_q;
          end
          if (tail_q[lvl_q] == cur_q) begin
            tail_d[lvl_q] = prev_q;
          end
        end else begin
          prev_d = cur_q;
          cur_d  = rd_link_q;
          if (is_entry(rd_link_q)) begin
            rd_en  = 1'b1;
            rd_ptr = rd_link_q;
          end else begin
            fin        = 1'b1;
            res_status = ST_NOTFOUND;
          end
        end
      end

      S_REM_FREE: begin
        fin        = 1'b1;
        res_status = ST_REMOVED;
        link_we    = 1'b1;
        link_wa    = cur_q;
        link_wd    = free_q;
        free_d     = cur_q;
      end

      S_DONE: begin
        fin        = 1'b1;
        res_status = done_status_q;
      end

      default: ;
    endcase
  end

  // Output register: load a finished result, drop it once taken.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    if (fin && adv) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status;
      out_data_d   = res_data;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= NULL_PTR;
        tail_q[i] <= NULL_PTR;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (adv) begin
        state_q <= state_d;
        head_q  <= head_d;
        tail_q  <= tail_d;
        free_q  <= free_d;
        fresh_q <= fresh_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    if (adv) begin
      lvl_q         <= lvl_d;
      id_q          <= id_d;
      cur_q         <= cur_d;
      prev_q        <= prev_d;
      done_status_q <= done_status_d;
    end
  end

  // Memories: read-first, one write port each, registered read.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_link_q <= link_mem[rd_ptr[ADDR_W-1:0]];
      rd_pay_q  <= pay_mem[rd_ptr[ADDR_W-1:0]];
    end
    if (link_we && adv) begin
      link_mem[link_wa[ADDR_W-1:0]] <= link_wd;
    end
    if (pay_we) begin
      pay_mem[free_q[ADDR_W-1:0]] <= '{ident:  in_data.event_id,
                                        device: in_data.device_handle,
                                        sensor: in_data.sensor_handle};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tlpeq_checker.sv
// Port-level checks on the result channel of the priority event queue.
// Depends on tlpeq_pkg; bound to three_level_priority_event_queue_unit below.
`default_nettype none

module tlpeq_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [tlpeq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input wire [tlpeq_pkg::STATUS_W-1:0]      m_axis_tuser
);

  import tlpeq_pkg::*;

  // Status stays within the defined codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= ST_NOTFOUND))
    else $error("result status outside defined codes");

  // Only a dispatch carries event fields.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_DISPATCHED)) |-> (m_axis_tdata == '0))
    else $error("non-dispatch result carries nonzero fields");

  // A dispatched event comes from one of the three queues.
  a_dsp_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_DISPATCHED)) |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("dispatched event from a nonexistent level");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind three_level_priority_event_queue_unit tlpeq_checker u_tlpeq_checker (.*);

`default_nettype wire
